FILE: rtl/dlb_pkg.sv
// shared widths, state and command types for the discrete log block
package dlb_pkg;

  localparam int RES_W = 31;
  localparam int MOD_W = 31;
  localparam int GEN_W = 31;
  localparam int BS_W  = 17;
  localparam int EXP_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_RGEN, ST_BCHK, ST_BRD, ST_BCHKE, ST_BMUL,
    ST_PWCHK, ST_PWMUL, ST_PWSQR, ST_DIV, ST_QSTART, ST_RRES, ST_QCHK,
    ST_QRD, ST_QCHKE, ST_QMUL, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_RED_GEN, MS_RED_RES, MS_BABY, MS_PMUL, MS_PSQR, MS_GIANT
  } mul_sel_t;

  typedef struct packed {
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     clr_start;
    logic     div_start;
    logic     ld_res;
    logic     baby_init;
    logic     baby_next;
    logic     pw_init1;
    logic     pw_init2;
    logic     pw_shift;
    logic     gf_ld;
    logic     q_init;
    logic     q_next;
    logic     hash_ld;
    logic     prb_rd;
    logic     prb_wr;
    logic     prb_next;
    logic     out_hit;
    logic     out_miss;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic j_done;
    logic e_zero;
    logic e_lsb;
    logic ent_valid;
    logic key_eq;
    logic prb_last;
    logic i_done;
  } sts_t;

endpackage

FILE: rtl/dlb_mulmod.sv
// bit-serial modular multiplier, one bit of b per cycle, msb first
module dlb_mulmod #(
  parameter int UW = 31,
  parameter int BW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [UW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [UW-1:0] n,
  output logic          busy,
  output logic          done,
  output logic [UW-1:0] r
);
  localparam int CW = $clog2(BW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [UW-1:0] a_r, n_r, r_r, r_nxt;
  logic [BW-1:0] b_r;
  logic [UW:0]   t1, t2;

  // requires a < n and r < n so each sum stays below 2n
  always_comb begin
    t1 = {r_r, 1'b0};
    if (t1 >= {1'b0, n_r}) t1 = t1 - {1'b0, n_r};
    t2 = t1;
    if (b_r[BW-1]) t2 = t1 + {1'b0, a_r};
    if (t2 >= {1'b0, n_r}) t2 = t2 - {1'b0, n_r};
    r_nxt = t2[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW - 1);
        r_r    <= '0;
        a_r    <= a;
        b_r    <= b;
        n_r    <= n;
      end else if (busy_r) begin
        r_r   <= r_nxt;
        b_r   <= b_r << 1;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r | done_r;
  assign done = done_r;
  assign r    = r_r;
endmodule

FILE: rtl/dlb_dp.sv
// datapath: store memory, multiplier, divider and working registers
module dlb_dp #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MOD_BITS    = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dlb_pkg::cmd_t            cmd,
  output dlb_pkg::sts_t            sts,
  input  logic [dlb_pkg::MOD_W-1:0] modulus,
  input  logic [dlb_pkg::GEN_W-1:0] generator,
  input  logic [dlb_pkg::BS_W-1:0]  baby_steps,
  input  logic [dlb_pkg::RES_W-1:0] residue,
  output logic                     out_found,
  output logic [dlb_pkg::EXP_W-1:0] out_exponent
);
  import dlb_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int DW  = $clog2(TABLE_DEPTH + 1);
  localparam int UW  = (MOD_BITS > DW) ? MOD_BITS : DW;
  localparam int BW  = (UW > RES_W) ? UW : RES_W;
  localparam int EW  = 1 + AW + MOD_BITS;
  localparam int MCW = $clog2(MOD_BITS);
  localparam int LW  = MOD_BITS + 1;

  logic [MOD_BITS-1:0] p_raw, p_eff;
  logic [DW-1:0]       m_eff;

  logic [RES_W-1:0]    res_r;
  logic [MOD_BITS-1:0] g_r, v_r, pr_r, pb_r, gf_r;
  logic [UW-1:0]       e_r;
  logic [DW-1:0]       j_r;
  logic [AW-1:0]       slot_r, n_r;
  logic [LW-1:0]       i_r, lim_r;
  logic [EXP_W-1:0]    base_r, exp_r;
  logic                found_r;
  mul_sel_t            dest_r;

  logic [UW-1:0]       mul_a, mul_n, mul_r;
  logic [BW-1:0]       mul_b;
  logic                mul_busy, mul_done;

  logic                div_busy_r;
  logic [MCW-1:0]      div_cnt_r;
  logic [DW-1:0]       rem_r;
  logic [MOD_BITS-1:0] dvd_r, quo_r, quo_nxt;
  logic [DW:0]         div_t;
  logic                div_ge;

  logic                clr_busy_r;
  logic [AW-1:0]       clr_addr_r;

  logic [AW-1:0]       hash_lo, hash_slot;

  logic [EW-1:0]       mem [TABLE_DEPTH];
  logic [EW-1:0]       rd_r, mem_wd;
  logic [AW-1:0]       mem_wa;
  logic                mem_we;
  logic                ent_valid;
  logic [AW-1:0]       ent_exp;
  logic [MOD_BITS-1:0] ent_key;

  // effective modulus and stride
  assign p_raw = MOD_BITS'(modulus);
  assign p_eff = (p_raw < MOD_BITS'(2)) ? MOD_BITS'(2) : p_raw;

  always_comb begin
    if (baby_steps == '0) m_eff = DW'(1);
    else if (32'(baby_steps) > 32'(TABLE_DEPTH)) m_eff = DW'(TABLE_DEPTH);
    else m_eff = DW'(baby_steps);
  end

  // home slot from the low key bits, folded once into the table range
  assign hash_lo   = AW'(v_r);
  assign hash_slot = (32'(hash_lo) >= 32'(TABLE_DEPTH)) ?
                     AW'(32'(hash_lo) - 32'(TABLE_DEPTH)) : hash_lo;

  // multiplier operand select
  always_comb begin
    mul_a = UW'(1);
    mul_b = BW'(v_r);
    mul_n = UW'(p_eff);
    unique case (cmd.mul_sel)
      MS_RED_GEN: mul_b = BW'(generator);
      MS_RED_RES: mul_b = BW'(res_r);
      MS_BABY: begin
        mul_a = UW'(v_r);
        mul_b = BW'(g_r);
      end
      MS_PMUL: begin
        mul_a = UW'(pr_r);
        mul_b = BW'(pb_r);
      end
      MS_PSQR: begin
        mul_a = UW'(pb_r);
        mul_b = BW'(pb_r);
      end
      MS_GIANT: begin
        mul_a = UW'(v_r);
        mul_b = BW'(gf_r);
      end
      default: ;
    endcase
  end

  dlb_mulmod #(.UW(UW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .n     (mul_n),
    .busy  (mul_busy),
    .done  (mul_done),
    .r     (mul_r)
  );

  // restoring divider step for p / m
  assign div_t   = {rem_r, dvd_r[MOD_BITS-1]};
  assign div_ge  = div_t >= {1'b0, m_eff};
  assign quo_nxt = {quo_r[MOD_BITS-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      clr_busy_r <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= MCW'(MOD_BITS - 1);
        rem_r      <= '0;
        dvd_r      <= p_eff;
        quo_r      <= '0;
      end else if (div_busy_r) begin
        rem_r     <= div_ge ? DW'(div_t - {1'b0, m_eff}) : DW'(div_t);
        dvd_r     <= dvd_r << 1;
        quo_r     <= quo_nxt;
        div_cnt_r <= div_cnt_r - MCW'(1);
        if (div_cnt_r == '0) begin
          div_busy_r <= 1'b0;
          lim_r      <= LW'(quo_nxt) + LW'(1);
        end
      end
      if (cmd.clr_start) begin
        clr_busy_r <= 1'b1;
        clr_addr_r <= '0;
      end else if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(TABLE_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
    end
  end

  // store memory: entry is {valid, exponent, key}
  assign mem_we = clr_busy_r | cmd.prb_wr;
  assign mem_wa = clr_busy_r ? clr_addr_r : slot_r;
  assign mem_wd = clr_busy_r ? '0 : {1'b1, AW'(j_r), v_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.prb_rd) rd_r <= mem[slot_r];
  end

  assign ent_valid = rd_r[EW-1];
  assign ent_exp   = rd_r[MOD_BITS +: AW];
  assign ent_key   = rd_r[MOD_BITS-1:0];

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_res) res_r <= residue;
    if (cmd.mul_start) dest_r <= cmd.mul_sel;
    if (mul_done) begin
      case (dest_r)
        MS_RED_GEN: g_r <= MOD_BITS'(mul_r);
        MS_RED_RES, MS_BABY, MS_GIANT: v_r <= MOD_BITS'(mul_r);
        MS_PMUL: pr_r <= MOD_BITS'(mul_r);
        MS_PSQR: pb_r <= MOD_BITS'(mul_r);
        default: ;
      endcase
    end
    if (cmd.baby_init) begin
      v_r <= MOD_BITS'(1);
      j_r <= '0;
    end
    if (cmd.baby_next) j_r <= j_r + DW'(1);
    if (cmd.pw_init1) begin
      pr_r <= MOD_BITS'(1);
      pb_r <= g_r;
      e_r  <= UW'(p_eff - MOD_BITS'(2));
    end
    if (cmd.pw_init2) begin
      pr_r <= MOD_BITS'(1);
      pb_r <= pr_r;
      e_r  <= UW'(m_eff);
    end
    if (cmd.pw_shift) e_r <= e_r >> 1;
    if (cmd.gf_ld) gf_r <= pr_r;
    if (cmd.q_init) begin
      i_r    <= '0;
      base_r <= '0;
    end
    if (cmd.q_next) begin
      i_r    <= i_r + LW'(1);
      base_r <= base_r + EXP_W'(m_eff);
    end
    if (cmd.hash_ld) begin
      slot_r <= hash_slot;
      n_r    <= '0;
    end
    if (cmd.prb_next) begin
      slot_r <= (slot_r == AW'(TABLE_DEPTH - 1)) ? '0 : slot_r + AW'(1);
      n_r    <= n_r + AW'(1);
    end
    if (cmd.out_hit) begin
      found_r <= 1'b1;
      exp_r   <= base_r + EXP_W'(ent_exp);
    end
    if (cmd.out_miss) begin
      found_r <= 1'b0;
      exp_r   <= '0;
    end
  end

  assign sts.busy      = mul_busy | div_busy_r | clr_busy_r;
  assign sts.j_done    = (j_r == m_eff);
  assign sts.e_zero    = (e_r == '0);
  assign sts.e_lsb     = e_r[0];
  assign sts.ent_valid = ent_valid;
  assign sts.key_eq    = (ent_key == v_r);
  assign sts.prb_last  = (n_r == AW'(TABLE_DEPTH - 1));
  assign sts.i_done    = (i_r == lim_r);

  assign out_found    = found_r;
  assign out_exponent = exp_r;
endmodule

FILE: rtl/dlb_ctrl.sv
// controller state machine sequencing build, exponentiation and search
module dlb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cfg_wr,
  output logic          busy,
  output logic          out_valid,
  output dlb_pkg::cmd_t cmd,
  input  dlb_pkg::sts_t sts
);
  import dlb_pkg::*;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   pw2_r, pw2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
      pw2_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      pw2_r   <= pw2_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ready_nxt   = ready_r;
    pw2_nxt     = pw2_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: if (start) begin
        cmd.ld_res = 1'b1;
        if (ready_r) begin
          state_nxt = ST_QSTART;
        end else begin
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLR;
        end
      end
      ST_CLR: if (!sts.busy) begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_RED_GEN;
        state_nxt     = ST_RGEN;
      end
      ST_RGEN: if (!sts.busy) begin
        cmd.baby_init = 1'b1;
        state_nxt     = ST_BCHK;
      end
      ST_BCHK: begin
        if (sts.j_done) begin
          cmd.pw_init1 = 1'b1;
          pw2_nxt      = 1'b0;
          state_nxt    = ST_PWCHK;
        end else begin
          cmd.hash_ld = 1'b1;
          state_nxt   = ST_BRD;
        end
      end
      ST_BRD: begin
        cmd.prb_rd = 1'b1;
        state_nxt  = ST_BCHKE;
      end
      ST_BCHKE: begin
        if (!sts.ent_valid || sts.key_eq || sts.prb_last) begin
          cmd.prb_wr    = !sts.ent_valid;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_BABY;
          state_nxt     = ST_BMUL;
        end else begin
          cmd.prb_next = 1'b1;
          state_nxt    = ST_BRD;
        end
      end
      ST_BMUL: if (!sts.busy) begin
        cmd.baby_next = 1'b1;
        state_nxt     = ST_BCHK;
      end
      ST_PWCHK: begin
        if (sts.e_zero) begin
          if (!pw2_r) begin
            cmd.pw_init2 = 1'b1;
            pw2_nxt      = 1'b1;
          end else begin
            cmd.gf_ld     = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else if (sts.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_PMUL;
          state_nxt     = ST_PWMUL;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_PSQR;
          state_nxt     = ST_PWSQR;
        end
      end
      ST_PWMUL: if (!sts.busy) begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_PSQR;
        state_nxt     = ST_PWSQR;
      end
      ST_PWSQR: if (!sts.busy) begin
        cmd.pw_shift = 1'b1;
        state_nxt    = ST_PWCHK;
      end
      ST_DIV: if (!sts.busy) begin
        ready_nxt = 1'b1;
        state_nxt = ST_QSTART;
      end
      ST_QSTART: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_RED_RES;
        state_nxt     = ST_RRES;
      end
      ST_RRES: if (!sts.busy) begin
        cmd.q_init = 1'b1;
        state_nxt  = ST_QCHK;
      end
      ST_QCHK: begin
        if (sts.i_done) begin
          cmd.out_miss = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.hash_ld = 1'b1;
          state_nxt   = ST_QRD;
        end
      end
      ST_QRD: begin
        cmd.prb_rd = 1'b1;
        state_nxt  = ST_QCHKE;
      end
      ST_QCHKE: begin
        if (sts.ent_valid && sts.key_eq) begin
          cmd.out_hit = 1'b1;
          state_nxt   = ST_DONE;
        end else if (!sts.ent_valid || sts.prb_last) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_GIANT;
          state_nxt     = ST_QMUL;
        end else begin
          cmd.prb_next = 1'b1;
          state_nxt    = ST_QRD;
        end
      end
      ST_QMUL: if (!sts.busy) begin
        cmd.q_next = 1'b1;
        state_nxt  = ST_QCHK;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) ready_nxt = 1'b0;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
endmodule

FILE: rtl/discrete_log_bsgs.sv
// top level of the baby-step giant-step discrete logarithm engine
//
// A query is accepted on start while busy is low; busy stays high until the
// single result has been shown, and the result is valid on out_found and
// out_exponent in the one cycle that out_valid is high. The receiver
// cannot stall it, so it must take the transfer in that cycle. The work is
// done in one shared bit-serial modular multiplier of B = max(31, MOD_BITS,
// clog2(TABLE_DEPTH+1)) bits, the store memory port or the bit-serial
// divider. The store's home slot comes combinationally from the low key
// bits. The first query after reset or after a register write first rebuilds
// the store: a clearing pass over all TABLE_DEPTH slots, then per baby step
// the probes and a multiply, two exponentiations (a Fermat inverse of the
// generator, then its power to the baby-step count) and a division of the
// modulus by the baby-step count. A query then reduces the residue and runs
// at most modulus/baby_steps+1 giant steps, each with its probes and a
// multiply.
module discrete_log_bsgs #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MOD_BITS    = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // query channel
  input  logic                      start,
  output logic                      busy,
  input  logic [dlb_pkg::RES_W-1:0] in_residue,
  // result channel
  output logic                      out_valid,
  output logic                      out_found,
  output logic [dlb_pkg::EXP_W-1:0] out_exponent,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dlb_pkg::*;

  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_GENERATOR  = 2'd1;
  localparam logic [1:0] REG_BABY_STEPS = 2'd2;

  logic [MOD_W-1:0] modulus_r;
  logic [GEN_W-1:0] generator_r;
  logic [BS_W-1:0]  baby_steps_r;
  logic             wr_en;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  cmd_t             cmd;
  sts_t             sts;

  // register writes complete in the access phase; no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // any write to a defined register invalidates the store
  always_comb begin
    cfg_wr = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODULUS, REG_GENERATOR, REG_BABY_STEPS: cfg_wr = 1'b1;
        default: cfg_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MOD_W'(2);
      generator_r  <= GEN_W'(1);
      baby_steps_r <= BS_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODULUS:    modulus_r    <= pwdata[MOD_W-1:0];
        REG_GENERATOR:  generator_r  <= pwdata[GEN_W-1:0];
        REG_BABY_STEPS: baby_steps_r <= pwdata[BS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MODULUS:    prdata = 32'(modulus_r);
      REG_GENERATOR:  prdata = 32'(generator_r);
      REG_BABY_STEPS: prdata = 32'(baby_steps_r);
      default:        prdata = '0;
    endcase
  end

  // sequencing of build and search
  dlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_wr    (cfg_wr),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store, arithmetic units and result registers
  dlb_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MOD_BITS(MOD_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .modulus      (modulus_r),
    .generator    (generator_r),
    .baby_steps   (baby_steps_r),
    .residue      (in_residue),
    .out_found    (out_found),
    .out_exponent (out_exponent)
  );
endmodule

FILE: rtl/dlb_chk.sv
// port-level checker for the discrete log block and its bind
module dlb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [30:0] in_residue,
  input logic        out_valid,
  input logic        out_found,
  input logic [31:0] out_exponent,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  // a result strobe lasts a single cycle and ends the query
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe not single");

  // results only appear while a query is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a query");

  // a miss reports exponent zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_exponent == 32'd0) else $error("miss with exponent");

  // an accepted query makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid) else $error("query not taken");
endmodule

bind discrete_log_bsgs dlb_chk u_dlb_chk (.*);
